FILE: sv/assert_macros.svh
// Assertion helpers used by the flip angle map core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold on every clock edge out of reset
`define AFM_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define AFM_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AFM_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/afm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afm_pkg
// Types, constants and the arctangent table of the flip angle map pipeline.
// ----------------------------------------------------------------------------
package afm_pkg;

  localparam int QBITS        = 30;            // fraction bits of |cos|
  localparam int QW           = QBITS + 1;     // Q1.30
  localparam int CORDIC_STEPS = 18;
  localparam int ZW           = 25;            // degrees Q.16, signed

  localparam logic [15:0]   TR_RESET  = 16'd1280;
  localparam logic [15:0]   ANGLE_MAX = 16'd46080;
  localparam logic [ZW-1:0] DEG90     = ZW'(90 * 65536);
  localparam logic [ZW-1:0] DEG180    = ZW'(180 * 65536);

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_CLAMP = 2'd1;
  localparam logic [1:0] STATUS_DIV0  = 2'd2;

  typedef struct packed {
    logic bad;    // zero first magnitude or zero denominator
    logic clamp;  // acos argument beyond unity
    logic neg;    // negative argument
  } flags_t;

  // atan(2^-i) in degrees, Q.16
  function automatic logic signed [ZW-1:0] atan_deg(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = ZW'(2949120);
      1:       v = ZW'(1740967);
      2:       v = ZW'(919879);
      3:       v = ZW'(466945);
      4:       v = ZW'(234379);
      5:       v = ZW'(117304);
      6:       v = ZW'(58666);
      7:       v = ZW'(29335);
      8:       v = ZW'(14668);
      9:       v = ZW'(7334);
      10:      v = ZW'(3667);
      11:      v = ZW'(1833);
      12:      v = ZW'(917);
      13:      v = ZW'(458);
      14:      v = ZW'(229);
      15:      v = ZW'(115);
      16:      v = ZW'(57);
      17:      v = ZW'(29);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/afm_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afm_isqrt
// Pipelined integer square root, one root bit per stage, with side tag.
// ----------------------------------------------------------------------------
module afm_isqrt #(
  parameter int IN_W  = 32,
  parameter int LANES = 1,
  parameter int TAG_W = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [LANES-1:0][IN_W-1:0]       in_val,
  input  logic [TAG_W-1:0]                 in_tag,
  output logic                             out_valid,
  output logic [LANES-1:0][IN_W/2-1:0]     out_root,
  output logic [TAG_W-1:0]                 out_tag
);

  localparam int OW = IN_W / 2;
  localparam int RW = OW + 3;

  logic                         vld  [0:OW];
  logic [LANES-1:0][IN_W-1:0]   val  [0:OW];
  logic [LANES-1:0][RW-1:0]     rem  [0:OW];
  logic [LANES-1:0][OW-1:0]     root [0:OW];
  logic [TAG_W-1:0]             tag  [0:OW];

  assign vld[0]  = in_valid;
  assign val[0]  = in_val;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign tag[0]  = in_tag;

  for (genvar k = 0; k < OW; k++) begin : g_stage
    logic [LANES-1:0][RW-1:0] cat;
    logic [LANES-1:0][RW-1:0] trial;
    logic [LANES-1:0]         ge;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        cat[l]   = {rem[k][l][RW-3:0], val[k][l][IN_W-1 -: 2]};
        trial[l] = RW'({root[k][l], 2'b01});
        ge[l]    = cat[l] >= trial[l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < LANES; l++) begin
        rem[k+1][l]  <= ge[l] ? (cat[l] - trial[l]) : cat[l];
        root[k+1][l] <= {root[k][l][OW-2:0], ge[l]};
        val[k+1][l]  <= val[k][l] << 2;
      end
      tag[k+1] <= tag[k];
    end
  end

  assign out_valid = vld[OW];
  assign out_root  = root[OW];
  assign out_tag   = tag[OW];

endmodule

FILE: sv/afm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afm_div
// Pipelined restoring divider: floor(num * 2^30 / den) for num <= den.
// ----------------------------------------------------------------------------
module afm_div
  import afm_pkg::*;
#(
  parameter int DW    = 40,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [DW-1:0]    num,
  input  logic [DW-1:0]    den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [QW-1:0]    quot,
  output logic [TAG_W-1:0] out_tag
);

  logic             vld  [0:QBITS];
  logic [DW-1:0]    rem  [0:QBITS];
  logic [DW-1:0]    dens [0:QBITS];
  logic [QW-1:0]    q    [0:QBITS];
  logic [TAG_W-1:0] tag  [0:QBITS];
  logic             eq;

  assign eq = num == den;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem[0]  <= eq ? '0 : num;
    dens[0] <= den;
    q[0]    <= QW'(eq);
    tag[0]  <= in_tag;
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_step
    logic [DW:0] r2;
    logic [DW:0] diff;
    logic        ge;

    assign r2   = {rem[k], 1'b0};
    assign diff = r2 - {1'b0, dens[k]};
    assign ge   = r2 >= {1'b0, dens[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1]  <= ge ? diff[DW-1:0] : r2[DW-1:0];
      dens[k+1] <= dens[k];
      q[k+1]    <= {q[k][QW-2:0], ge};
      tag[k+1]  <= tag[k];
    end
  end

  assign out_valid = vld[QBITS];
  assign quot      = q[QBITS];
  assign out_tag   = tag[QBITS];

endmodule

FILE: sv/afm_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afm_cordic
// Vectoring CORDIC, one rotation per stage; angle of (x, y) in degrees Q.16,
// held to 0 .. 90 degrees.
// ----------------------------------------------------------------------------
module afm_cordic
  import afm_pkg::*;
#(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [QW-1:0]    x_in,
  input  logic [QW-1:0]    y_in,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [ZW-1:0]    z_out,
  output logic [TAG_W-1:0] out_tag
);

  localparam int CW = QW + 3;

  logic                 vld [0:CORDIC_STEPS];
  logic signed [CW-1:0] x   [0:CORDIC_STEPS];
  logic signed [CW-1:0] y   [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z   [0:CORDIC_STEPS];
  logic                 yz  [0:CORDIC_STEPS];
  logic [TAG_W-1:0]     tag [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x[0]   <= $signed({{(CW-QW){1'b0}}, x_in});
    y[0]   <= $signed({{(CW-QW){1'b0}}, y_in});
    z[0]   <= '0;
    yz[0]  <= y_in == '0;
    tag[0] <= in_tag;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic                 ypos;

    assign xs   = x[i] >>> i;
    assign ys   = y[i] >>> i;
    assign ypos = !y[i][CW-1] && (y[i] != '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ypos) begin
        x[i+1] <= x[i] + ys;
        y[i+1] <= y[i] - xs;
        z[i+1] <= z[i] + atan_deg(i);
      end else begin
        x[i+1] <= x[i] - ys;
        y[i+1] <= y[i] + xs;
        z[i+1] <= z[i] - atan_deg(i);
      end
      yz[i+1]  <= yz[i];
      tag[i+1] <= tag[i];
    end
  end

  always_comb begin
    if (yz[CORDIC_STEPS] || z[CORDIC_STEPS][ZW-1]) begin
      z_out = '0;
    end else if (z[CORDIC_STEPS] > $signed(DEG90)) begin
      z_out = DEG90;
    end else begin
      z_out = z[CORDIC_STEPS];
    end
  end

  assign out_valid = vld[CORDIC_STEPS];
  assign out_tag   = tag[CORDIC_STEPS];

endmodule

FILE: sv/afi_flip_angle_map_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afi_flip_angle_map_core
// AFI B1 map: flip angle acos((n*r-1)/(n-r)) per voxel, r = |S2|/|S1|.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  voxel     start, busy, first_re/im, last_re/im      in
//  result    done, angle_deg, status                   out
//  config    cfg_valid, cfg_ready, cfg_data (tr_ratio) in
//
//  One word per cycle; each word runs through the two square-root pipelines,
//  the 30-bit divider and the 18-step CORDIC.
//  rst is synchronous; it empties the pipeline and restores tr_ratio to 5.0.
//  busy stays low: nothing downstream can stall, so words never back up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module afi_flip_angle_map_core
  import afm_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] first_re,
  input  logic signed [SAMPLE_BITS-1:0] first_im,
  input  logic signed [SAMPLE_BITS-1:0] last_re,
  input  logic signed [SAMPLE_BITS-1:0] last_im,
  output logic                          done,
  output logic [15:0]                   angle_deg,
  output logic [1:0]                    status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [15:0]                   cfg_data
);

  localparam int SW   = SAMPLE_BITS;
  localparam int MF   = (SAMPLE_BITS >= 24) ? (32 - SAMPLE_BITS) : 8;
  localparam int SQW  = 2 * SW;
  localparam int SIW  = SQW + 2 * MF;
  localparam int MW   = SW + MF;
  localparam int NB   = 16 + MW;
  localparam int FW   = $bits(flags_t);
  localparam int VW   = 2 * QW;
  localparam int QTW  = QW + FW;

  localparam logic [VW-1:0] ONE_SQ = VW'(1) << (2 * QBITS);

  logic [15:0] tr_ratio;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tr_ratio <= TR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tr_ratio <= cfg_data;
    end
  end

  // squared magnitudes
  logic [SW-1:0]  fr_abs, fi_abs, lr_abs, li_abs;
  logic [SQW-1:0] fr_sq, fi_sq, lr_sq, li_sq;
  logic           s1_valid;
  logic [SQW-1:0] sq_a, sq_b;

  assign fr_abs = first_re[SW-1] ? SW'(-first_re) : SW'(first_re);
  assign fi_abs = first_im[SW-1] ? SW'(-first_im) : SW'(first_im);
  assign lr_abs = last_re[SW-1]  ? SW'(-last_re)  : SW'(last_re);
  assign li_abs = last_im[SW-1]  ? SW'(-last_im)  : SW'(last_im);
  assign fr_sq  = fr_abs * fr_abs;
  assign fi_sq  = fi_abs * fi_abs;
  assign lr_sq  = lr_abs * lr_abs;
  assign li_sq  = li_abs * li_abs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    sq_a <= fr_sq + fi_sq;
    sq_b <= lr_sq + li_sq;
  end

  // magnitudes
  logic [1:0][SIW-1:0] mag_in;
  logic                mag_valid;
  logic [1:0][MW-1:0]  mag;
  logic                a_zero;

  assign mag_in[0] = SIW'(sq_a) << (2 * MF);
  assign mag_in[1] = SIW'(sq_b) << (2 * MF);

  afm_isqrt #(.IN_W(SIW), .LANES(2), .TAG_W(1)) u_mag (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_val    (mag_in),
    .in_tag    (sq_a == '0),
    .out_valid (mag_valid),
    .out_root  (mag),
    .out_tag   (a_zero)
  );

  // numerator and denominator of the acos argument
  logic          s2_valid, s2_azero;
  logic [NB-1:0] prod_nb, prod_na, a_sh, b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= mag_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_nb  <= tr_ratio * mag[1];
    prod_na  <= tr_ratio * mag[0];
    a_sh     <= NB'(mag[0]) << 8;
    b_sh     <= NB'(mag[1]) << 8;
    s2_azero <= a_zero;
  end

  logic               s3_valid, s3_azero;
  logic signed [NB:0] num_p, den_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    num_p    <= $signed({1'b0, prod_nb}) - $signed({1'b0, a_sh});
    den_d    <= $signed({1'b0, prod_na}) - $signed({1'b0, b_sh});
    s3_azero <= s2_azero;
  end

  logic          s4_valid;
  logic [NB-1:0] p_abs, d_abs;
  flags_t        s4_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    p_abs          <= num_p[NB] ? NB'(-num_p) : NB'(num_p);
    d_abs          <= den_d[NB] ? NB'(-den_d) : NB'(den_d);
    s4_flags.bad   <= s3_azero || (den_d == '0);
    s4_flags.clamp <= 1'b0;
    s4_flags.neg   <= (num_p[NB] != den_d[NB]) && (num_p != '0);
  end

  logic          s5_valid;
  logic [NB-1:0] div_num, div_den;
  flags_t        s5_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    div_num  <= (p_abs > d_abs) ? d_abs : p_abs;
    div_den  <= d_abs;
    s5_flags <= '{bad: s4_flags.bad, clamp: (p_abs > d_abs), neg: s4_flags.neg};
  end

  // |argument| in Q1.30
  logic          div_valid;
  logic [QW-1:0] q_val;
  flags_t        div_flags;

  afm_div #(.DW(NB), .TAG_W(FW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_valid),
    .num       (div_num),
    .den       (div_den),
    .in_tag    (s5_flags),
    .out_valid (div_valid),
    .quot      (q_val),
    .out_tag   (div_flags)
  );

  // sine side: sqrt(1 - q^2)
  logic          s6_valid, s7_valid;
  logic [VW-1:0] q_sq, sin_sq;
  logic [QTW-1:0] s6_tag, s7_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
    end else begin
      s6_valid <= div_valid;
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    q_sq   <= q_val * q_val;
    s6_tag <= {q_val, div_flags};
    sin_sq <= ONE_SQ - q_sq;
    s7_tag <= s6_tag;
  end

  logic           sin_valid;
  logic [QW-1:0]  sin_val;
  logic [QTW-1:0] sin_tag;

  afm_isqrt #(.IN_W(VW), .LANES(1), .TAG_W(QTW)) u_sin (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s7_valid),
    .in_val    (sin_sq),
    .in_tag    (s7_tag),
    .out_valid (sin_valid),
    .out_root  (sin_val),
    .out_tag   (sin_tag)
  );

  // angle
  logic          ang_valid;
  logic [ZW-1:0] ang_z;
  flags_t        ang_flags;

  afm_cordic #(.TAG_W(FW)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sin_valid),
    .x_in      (sin_tag[QTW-1 -: QW]),
    .y_in      (sin_val),
    .in_tag    (sin_tag[FW-1:0]),
    .out_valid (ang_valid),
    .z_out     (ang_z),
    .out_tag   (ang_flags)
  );

  logic [ZW-1:0]   z_full;
  logic [ZW-1:0]   z_rnd;
  logic [ZW-9:0]   z_deg;
  logic [15:0]     angle_next;
  logic [1:0]      status_next;

  assign z_full = ang_flags.neg ? (DEG180 - ang_z) : ang_z;
  assign z_rnd  = z_full + ZW'(128);
  assign z_deg  = z_rnd[ZW-1:8];

  always_comb begin
    if (ang_flags.bad) begin
      angle_next  = '0;
      status_next = STATUS_DIV0;
    end else begin
      angle_next  = (z_deg > (ZW-8)'(ANGLE_MAX)) ? ANGLE_MAX : z_deg[15:0];
      status_next = ang_flags.clamp ? STATUS_CLAMP : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ang_valid;
    end
  end

  always_ff @(posedge clk) begin
    angle_deg <= angle_next;
    status    <= status_next;
  end

  `AFM_IMPLY(a_div0_zero, done && (status == STATUS_DIV0), angle_deg == '0, "div0 word with angle")
  `AFM_IMPLY(a_clamp_ends, done && (status == STATUS_CLAMP), (angle_deg == '0) || (angle_deg == ANGLE_MAX), "clamped angle not at an end")
  `AFM_IMPLY(a_word_range, done, (angle_deg <= ANGLE_MAX) && ((status == STATUS_OK) || (status == STATUS_CLAMP) || (status == STATUS_DIV0)), "result word out of range")
  `AFM_NEXT(a_cfg_write, cfg_valid && cfg_ready, tr_ratio == $past(cfg_data), "tr_ratio not written")

endmodule
